// ===== hdl/assert_macros.svh =====
// assertion macros used by the spn64 cipher rtl
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/spn64_pkg.sv =====
// types, constants and cipher functions for the spn64 block cipher
// no dependencies
package spn64_pkg;

  localparam int BLOCK_W   = 64;
  localparam int NIBBLES   = BLOCK_W / 4;
  localparam int ROUNDS    = 4;
  localparam int NUM_KEYS  = ROUNDS + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LAST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_IV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_ENABLE = 3'd4;

  localparam logic [BLOCK_W-1:0] CHAIN_IV_RESET = 64'd22220012;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [NUM_KEYS-1:0][BLOCK_W-1:0] rkeys_t;

  typedef struct packed {
    block_t chain_iv;
    logic   decrypt;
    logic   chain_enable;
  } mode_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'd14;
      4'h1: r = 4'd4;
      4'h2: r = 4'd13;
      4'h3: r = 4'd1;
      4'h4: r = 4'd2;
      4'h5: r = 4'd15;
      4'h6: r = 4'd11;
      4'h7: r = 4'd8;
      4'h8: r = 4'd3;
      4'h9: r = 4'd10;
      4'ha: r = 4'd6;
      4'hb: r = 4'd12;
      4'hc: r = 4'd5;
      4'hd: r = 4'd9;
      4'he: r = 4'd0;
      4'hf: r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'd14;
      4'h1: r = 4'd3;
      4'h2: r = 4'd4;
      4'h3: r = 4'd8;
      4'h4: r = 4'd1;
      4'h5: r = 4'd12;
      4'h6: r = 4'd10;
      4'h7: r = 4'd15;
      4'h8: r = 4'd7;
      4'h9: r = 4'd13;
      4'ha: r = 4'd9;
      4'hb: r = 4'd6;
      4'hc: r = 4'd11;
      4'hd: r = 4'd2;
      4'he: r = 4'd0;
      4'hf: r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic block_t subst(input block_t x, input logic inv);
    block_t r;
    r = '0;
    for (int n = 0; n < NIBBLES; n++) begin
      r[4*n +: 4] = inv ? sbox_inv(x[4*n +: 4]) : sbox_fwd(x[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i takes bit {i[1:0], i[5:2]} forward, {i[3:0], i[5:4]} inverse
  function automatic block_t permute(input block_t x, input logic inv);
    block_t     r;
    logic [5:0] ib;
    logic [5:0] src;
    r = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      ib     = 6'(i);
      src    = inv ? {ib[3:0], ib[5:4]} : {ib[1:0], ib[5:2]};
      r[i]   = x[src];
    end
    return r;
  endfunction

endpackage

// ===== hdl/spn64_ifs.sv =====
// valid/ready channel interfaces for the spn64 cipher input and result items
// depends on spn64_pkg
interface spn64_in_if;
  logic                           valid;
  logic                           ready;
  logic [spn64_pkg::BLOCK_W-1:0]  data_block;
  logic                           chain_start;

  modport source (output valid, data_block, chain_start, input ready);
  modport sink (input valid, data_block, chain_start, output ready);
endinterface

interface spn64_out_if;
  logic                           valid;
  logic                           ready;
  logic [spn64_pkg::BLOCK_W-1:0]  result_block;

  modport source (output valid, result_block, input ready);
  modport sink (input valid, result_block, output ready);
endinterface

// ===== hdl/spn64_block_cipher_cbc_unit.sv =====
// 64-bit four-round spn block cipher with optional cbc chaining when encrypting
// Accepts one block per clock and returns one block per clock while the
// result side is not stalled. An accepted item sits in an input register,
// is chained, passes all four rounds and lands in the result register. The
// path from the previous ciphertext register through the chaining xor and four
// rounds is combinational and sets the rate. Configuration writes take effect
// on the next cycle; the user makes them while idle, the block does not check.
// depends on spn64_pkg, spn64_ifs, spn64_cfg, spn64_round, assert_macros.svh
`include "assert_macros.svh"

module spn64_block_cipher_cbc_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [spn64_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spn64_pkg::BLOCK_W-1:0]   cfg_data,
  spn64_in_if.sink                        in_ch,
  spn64_out_if.source                     out_ch
);

  spn64_pkg::mode_t  mode;
  spn64_pkg::rkeys_t rkeys;

  logic              s_valid;
  spn64_pkg::block_t s_block;
  logic              s_start;
  logic              o_valid;
  spn64_pkg::block_t o_block;
  spn64_pkg::block_t prev_cipher;

  logic              advance;
  spn64_pkg::block_t chained;
  spn64_pkg::block_t result;

  spn64_pkg::block_t rnd [spn64_pkg::ROUNDS+1];

  spn64_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .rkeys     (rkeys)
  );

  assign advance     = s_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_block <= in_ch.data_block;
      s_start <= in_ch.chain_start;
    end
  end

  always_comb begin
    if (!mode.decrypt && mode.chain_enable) begin
      chained = s_block ^ (s_start ? mode.chain_iv : prev_cipher);
    end else begin
      chained = s_block;
    end
  end

  assign rnd[0] = chained;

  for (genvar r = 0; r < spn64_pkg::ROUNDS; r++) begin : g_round
    spn64_round u_round (
      .x_in    (rnd[r]),
      .rkey    (rkeys[r]),
      .decrypt (mode.decrypt),
      .perm_en (r != spn64_pkg::ROUNDS - 1),
      .x_out   (rnd[r+1])
    );
  end

  assign result = rnd[spn64_pkg::ROUNDS] ^ rkeys[spn64_pkg::ROUNDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid     <= 1'b0;
      prev_cipher <= '0;
    end else if (advance) begin
      o_valid <= 1'b1;
      if (!mode.decrypt) begin
        prev_cipher <= result;
      end
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_block <= result;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.result_block = o_block;

  `ASSERT_IMPL(a_ready_when_empty, !o_valid, in_ch.ready)
  `ASSERT_NEXT(a_stage_kept, s_valid && !advance, s_valid)
  `ASSERT_NEXT(a_prev_tracks_result, advance && !mode.decrypt, prev_cipher == o_block)
  `ASSERT_NEXT(a_prev_held_decrypt, mode.decrypt, $stable(prev_cipher))

endmodule

// ===== hdl/spn64_cfg.sv =====
// configuration registers and round key schedule of the spn64 cipher
// depends on spn64_pkg
module spn64_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [spn64_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spn64_pkg::BLOCK_W-1:0]   cfg_data,
  output spn64_pkg::mode_t                mode,
  output spn64_pkg::rkeys_t               rkeys
);

  spn64_pkg::block_t key_first;
  spn64_pkg::block_t key_last;
  spn64_pkg::block_t chain_iv;
  logic              decrypt;
  logic              chain_enable;

  spn64_pkg::block_t k1;
  spn64_pkg::block_t k2;
  spn64_pkg::block_t k3;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first    <= '0;
      key_last     <= '0;
      chain_iv     <= spn64_pkg::CHAIN_IV_RESET;
      decrypt      <= 1'b0;
      chain_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        spn64_pkg::CFG_KEY_FIRST:    key_first    <= cfg_data;
        spn64_pkg::CFG_KEY_LAST:     key_last     <= cfg_data;
        spn64_pkg::CFG_CHAIN_IV:     chain_iv     <= cfg_data;
        spn64_pkg::CFG_DECRYPT:      decrypt      <= cfg_data[0];
        spn64_pkg::CFG_CHAIN_ENABLE: chain_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // middle keys spliced from the two configured words
  assign k1 = {key_first[47:0], 16'h0} ^ {48'h0, key_last[63:48]};
  assign k2 = {key_first[31:0], 32'h0} ^ {32'h0, key_last[63:32]};
  assign k3 = {key_first[15:0], 48'h0} ^ {16'h0, key_last[63:16]};

  always_comb begin
    if (decrypt) begin
      rkeys[0] = key_last;
      rkeys[1] = spn64_pkg::permute(k3, 1'b1);
      rkeys[2] = spn64_pkg::permute(k2, 1'b1);
      rkeys[3] = spn64_pkg::permute(k1, 1'b1);
      rkeys[4] = key_first;
    end else begin
      rkeys[0] = key_first;
      rkeys[1] = k1;
      rkeys[2] = k2;
      rkeys[3] = k3;
      rkeys[4] = key_last;
    end
  end

  assign mode.chain_iv     = chain_iv;
  assign mode.decrypt      = decrypt;
  assign mode.chain_enable = chain_enable;

endmodule

// ===== hdl/spn64_round.sv =====
// one cipher round: key mix, nibble substitution, optional bit permutation
// depends on spn64_pkg
module spn64_round (
  input  spn64_pkg::block_t x_in,
  input  spn64_pkg::block_t rkey,
  input  logic              decrypt,
  input  logic              perm_en,
  output spn64_pkg::block_t x_out
);

  spn64_pkg::block_t sub;

  assign sub   = spn64_pkg::subst(x_in ^ rkey, decrypt);
  assign x_out = perm_en ? spn64_pkg::permute(sub, decrypt) : sub;

endmodule

// ===== tb/spn64_block_cipher_cbc_unit_test.sv =====
// self-checking bench for the spn64 cbc cipher unit: directed and random items
// are checked against a behavioral cipher with its own keys, iv and chain state
// depends on spn64_pkg, spn64_ifs and spn64_block_cipher_cbc_unit
module spn64_block_cipher_cbc_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    spn64_pkg::block_t data;
    logic              start;
  } plain_item_t;

  localparam bit [3:0] SBOX_ENC [16] = '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
                                         4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7};
  localparam bit [3:0] SBOX_DEC [16] = '{4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
                                         4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5};
  localparam spn64_pkg::block_t ALL_ONES = '1;
  localparam int     PHASES         = 12;
  localparam int     PHASE_ITEMS    = 152;
  localparam int     PRESSURE_PHASE = 4;
  localparam int     SETTLE_CYCLES  = 6;
  localparam int     MAX_SHOWN      = 100;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [spn64_pkg::CFG_IDX_W-1:0] cfg_index;
  spn64_pkg::block_t               cfg_data;

  spn64_in_if  in_ch ();
  spn64_out_if out_ch ();

  spn64_block_cipher_cbc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  spn64_pkg::block_t key_first_q;
  spn64_pkg::block_t key_last_q;
  spn64_pkg::block_t iv_q;
  spn64_pkg::block_t last_cipher_q;
  logic              decrypt_q;
  logic              chain_q;

  plain_item_t       pending_blocks [$];
  spn64_pkg::block_t expected_blocks [$];
  plain_item_t       next_item;
  spn64_pkg::block_t want_block;

  int errors         = 0;
  int blocks_in      = 0;
  int blocks_checked = 0;
  int dec_count      = 0;
  int chained_count  = 0;
  int send_gap       = 0;
  int recv_stall     = 0;
  bit idle_on        = 1'b1;
  bit hold_sender    = 1'b0;
  bit in_fire        = 1'b0;

  always #5 clk = ~clk;

  function automatic spn64_pkg::block_t sub_layer(spn64_pkg::block_t x, logic inv);
    spn64_pkg::block_t r;
    for (int n = 0; n < spn64_pkg::NIBBLES; n++) begin
      r[4*n +: 4] = inv ? SBOX_DEC[x[4*n +: 4]] : SBOX_ENC[x[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic spn64_pkg::block_t bit_layer(spn64_pkg::block_t x, logic inv);
    spn64_pkg::block_t r;
    int                src;
    for (int i = 0; i < spn64_pkg::BLOCK_W; i++) begin
      src  = inv ? ((i % 16) * 4 + i / 16) : ((i % 4) * 16 + i / 4);
      r[i] = x[src];
    end
    return r;
  endfunction

  function automatic spn64_pkg::block_t cipher_block(spn64_pkg::block_t x, logic inv);
    spn64_pkg::block_t mid [3];
    spn64_pkg::block_t rk [spn64_pkg::NUM_KEYS];
    spn64_pkg::block_t s;
    mid[0] = (key_first_q << 16) ^ (key_last_q >> 48);
    mid[1] = (key_first_q << 32) ^ (key_last_q >> 32);
    mid[2] = (key_first_q << 48) ^ (key_last_q >> 16);
    if (inv) begin
      rk[0] = key_last_q;
      rk[1] = bit_layer(mid[2], 1'b1);
      rk[2] = bit_layer(mid[1], 1'b1);
      rk[3] = bit_layer(mid[0], 1'b1);
      rk[4] = key_first_q;
    end else begin
      rk[0] = key_first_q;
      rk[1] = mid[0];
      rk[2] = mid[1];
      rk[3] = mid[2];
      rk[4] = key_last_q;
    end
    s = x;
    for (int r = 0; r < spn64_pkg::ROUNDS - 1; r++) begin
      s = bit_layer(sub_layer(s ^ rk[r], inv), inv);
    end
    s = sub_layer(s ^ rk[spn64_pkg::ROUNDS-1], inv);
    return s ^ rk[spn64_pkg::ROUNDS];
  endfunction

  function automatic spn64_pkg::block_t next_result(spn64_pkg::block_t data, logic start);
    spn64_pkg::block_t x;
    if (decrypt_q) begin
      return cipher_block(data, 1'b1);
    end
    x = data;
    if (chain_q) begin
      x = x ^ (start ? iv_q : last_cipher_q);
    end
    last_cipher_q = cipher_block(x, 1'b0);
    return last_cipher_q;
  endfunction

  function automatic spn64_pkg::block_t rand_block();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ALL_ONES;
      2: return spn64_pkg::block_t'(1) << $urandom_range(0, spn64_pkg::BLOCK_W - 1);
      3: return ~(spn64_pkg::block_t'(1) << $urandom_range(0, spn64_pkg::BLOCK_W - 1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(string what, spn64_pkg::block_t got,
                                 spn64_pkg::block_t want);
    if (errors < MAX_SHOWN) begin
      $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic set_reg(logic [spn64_pkg::CFG_IDX_W-1:0] idx, spn64_pkg::block_t value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      spn64_pkg::CFG_KEY_FIRST:    key_first_q = value;
      spn64_pkg::CFG_KEY_LAST:     key_last_q  = value;
      spn64_pkg::CFG_CHAIN_IV:     iv_q        = value;
      spn64_pkg::CFG_DECRYPT:      decrypt_q   = value[0];
      spn64_pkg::CFG_CHAIN_ENABLE: chain_q     = value[0];
      default: ;
    endcase
  endtask

  task automatic send_block(spn64_pkg::block_t data, logic start);
    plain_item_t it;
    it.data  = data;
    it.start = start;
    pending_blocks.push_back(it);
  endtask

  task automatic wait_results();
    do begin
      @(posedge clk);
      #1;
    end while (in_ch.valid || expected_blocks.size() != 0);
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_blocks.size() != 0 || in_ch.valid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (hold_sender || pending_blocks.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_ch.valid <= 1'b0;
      end else begin
        next_item = pending_blocks.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.data_block  <= next_item.data;
        in_ch.chain_start <= next_item.start;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      recv_stall = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (decrypt_q) begin
        dec_count++;
      end else if (chain_q) begin
        chained_count++;
      end
      expected_blocks.push_back(next_result(in_ch.data_block, in_ch.chain_start));
      blocks_in++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("result with no item pending", out_ch.result_block, '0);
      end else begin
        want_block = expected_blocks.pop_front();
        if (out_ch.result_block !== want_block) begin
          report_mismatch("result_block", out_ch.result_block, want_block);
        end
        blocks_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int                count;
    int                seq_len;
    int                mark;
    bit                broken;
    spn64_pkg::block_t mode_word;

    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_block  = '0;
    in_ch.chain_start = 1'b0;
    out_ch.ready      = 1'b0;
    key_first_q       = '0;
    key_last_q        = '0;
    iv_q              = spn64_pkg::CHAIN_IV_RESET;
    last_cipher_q     = '0;
    decrypt_q         = 1'b0;
    chain_q           = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero keys, default iv, chaining on
    send_block('0, 1'b0);
    send_block(ALL_ONES, 1'b1);
    send_block('0, 1'b0);
    send_block(64'h0123_4567_89ab_cdef, 1'b1);
    settle();

    // chaining off, start flag ignored
    set_reg(spn64_pkg::CFG_KEY_FIRST, ALL_ONES);
    set_reg(spn64_pkg::CFG_KEY_LAST, '0);
    set_reg(spn64_pkg::CFG_CHAIN_ENABLE, ALL_ONES << 1);
    @(negedge clk);
    send_block('0, 1'b1);
    send_block(ALL_ONES, 1'b0);
    send_block(64'ha5a5_a5a5_a5a5_a5a5, 1'b1);
    settle();

    // inverse cipher, upper register bits set
    set_reg(spn64_pkg::CFG_KEY_FIRST, '0);
    set_reg(spn64_pkg::CFG_KEY_LAST, ALL_ONES);
    set_reg(spn64_pkg::CFG_DECRYPT, ALL_ONES);
    @(negedge clk);
    send_block('0, 1'b0);
    send_block(ALL_ONES, 1'b1);
    send_block(64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
    settle();

    // back to chained encrypt with all-ones keys and iv
    set_reg(spn64_pkg::CFG_KEY_FIRST, ALL_ONES);
    set_reg(spn64_pkg::CFG_CHAIN_IV, ALL_ONES);
    set_reg(spn64_pkg::CFG_DECRYPT, ALL_ONES << 1);
    set_reg(spn64_pkg::CFG_CHAIN_ENABLE, ALL_ONES);
    @(negedge clk);
    send_block('0, 1'b1);
    send_block('0, 1'b0);
    send_block(ALL_ONES, 1'b0);
    send_block(64'h8000_0000_0000_0001, 1'b0);
    settle();

    // writes to unused indexes change nothing
    for (int u = spn64_pkg::CFG_CHAIN_ENABLE + 1; u < (1 << spn64_pkg::CFG_IDX_W); u++) begin
      set_reg(spn64_pkg::CFG_IDX_W'(u), ALL_ONES);
    end
    @(negedge clk);
    send_block('0, 1'b1);
    send_block(64'h1, 1'b0);
    settle();

    set_reg(spn64_pkg::CFG_KEY_FIRST, {$urandom, $urandom});
    set_reg(spn64_pkg::CFG_KEY_LAST, {$urandom, $urandom});
    set_reg(spn64_pkg::CFG_DECRYPT, 64'h1);
    @(negedge clk);
    for (int k = 0; k < 4; k++) begin
      send_block({$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        set_reg(spn64_pkg::CFG_KEY_FIRST, ALL_ONES);
        set_reg(spn64_pkg::CFG_KEY_LAST, ALL_ONES);
        set_reg(spn64_pkg::CFG_CHAIN_IV, ALL_ONES);
      end else begin
        set_reg(spn64_pkg::CFG_KEY_FIRST, rand_block());
        set_reg(spn64_pkg::CFG_KEY_LAST, rand_block());
        set_reg(spn64_pkg::CFG_CHAIN_IV, rand_block());
      end
      mode_word    = {$urandom, $urandom};
      mode_word[0] = ($urandom_range(0, 3) == 0);
      set_reg(spn64_pkg::CFG_DECRYPT, mode_word);
      mode_word    = {$urandom, $urandom};
      mode_word[0] = ($urandom_range(0, 4) != 0);
      set_reg(spn64_pkg::CFG_CHAIN_ENABLE, mode_word);
      if ($urandom_range(0, 3) == 0) begin
        set_reg(spn64_pkg::CFG_IDX_W'(spn64_pkg::CFG_CHAIN_ENABLE + 1 + $urandom_range(0, 2)),
                rand_block());
      end
      idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      @(negedge clk);

      // mostly chains opened by a start item, some with a random start pattern
      mark  = blocks_in;
      count = 0;
      while (count < PHASE_ITEMS) begin
        seq_len = $urandom_range(1, 16);
        broken  = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < seq_len && count < PHASE_ITEMS; j++) begin
          send_block(rand_block(), broken ? 1'($urandom_range(0, 1)) : (j == 0));
          count++;
        end
      end

      if (ph == PRESSURE_PHASE) begin
        do begin
          @(posedge clk);
          #1;
        end while (blocks_in < mark + PHASE_ITEMS / 2);
        hold_sender = 1'b1;
        wait_results();
        hold_sender = 1'b0;
      end
      settle();
    end

    $display("covered %0d items: %0d inverse, %0d chained encrypt, the rest plain encrypt",
             blocks_in, dec_count, chained_count);
    $display("checked %0d results, %0d mismatches", blocks_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== spn64_block_cipher_cbc_unit.f =====
+incdir+hdl
hdl/spn64_pkg.sv
hdl/spn64_ifs.sv
hdl/spn64_cfg.sv
hdl/spn64_round.sv
hdl/spn64_block_cipher_cbc_unit.sv
tb/spn64_block_cipher_cbc_unit_test.sv
